FILE: hdl/pdadc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdadc_pkg: shared types and constants
// Field widths, debounce patterns and block length for the pin debounce and
// converter averaging block.
// ----------------------------------------------------------------------------
package pdadc_pkg;

    localparam int PIN_COUNT   = 9;
    localparam int SAMPLE_BITS = 12;
    localparam int HIST_BITS   = 8;
    localparam int AVG_BITS    = 16;
    localparam int BLOCK_TICKS = 32;
    localparam int COUNT_BITS  = $clog2(BLOCK_TICKS);
    localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;

    // one high then seven lows sets the bit; one low then seven highs clears it
    localparam logic [HIST_BITS-1:0] HIST_ROSE_LOW  = 8'h80;
    localparam logic [HIST_BITS-1:0] HIST_ROSE_HIGH = 8'h7F;
    localparam logic [HIST_BITS-1:0] HIST_INIT      = 8'hFF;

    localparam logic [COUNT_BITS-1:0] LAST_TICK = COUNT_BITS'(BLOCK_TICKS - 1);

    typedef struct packed {
        logic [PIN_COUNT-1:0]   pin_levels;
        logic [SAMPLE_BITS-1:0] adc_sample_a;
        logic [SAMPLE_BITS-1:0] adc_sample_b;
    } sample_t;

    typedef struct packed {
        logic [PIN_COUNT-1:0] debounced_bits;
        logic [AVG_BITS-1:0]  average_a;
        logic [AVG_BITS-1:0]  average_b;
        logic                 averages_updated;
    } result_t;

    typedef struct packed {
        logic [AVG_BITS-1:0] average_a;
        logic [AVG_BITS-1:0] average_b;
        logic                updated;
    } avg_status_t;

endpackage
`default_nettype wire

FILE: hdl/pdadc_debounce.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdadc_debounce: per-pin history debounce
// Shifts each pin level into an 8-sample history and sets or clears the
// qualified bit on the exact edge patterns.
// ----------------------------------------------------------------------------
module pdadc_debounce (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           enable,
    input  wire logic [pdadc_pkg::PIN_COUNT-1:0] levels,
    output logic      [pdadc_pkg::PIN_COUNT-1:0] qualified_next
);

    logic [pdadc_pkg::HIST_BITS-1:0] hist_reg  [pdadc_pkg::PIN_COUNT];
    logic [pdadc_pkg::HIST_BITS-1:0] hist_next [pdadc_pkg::PIN_COUNT];
    logic [pdadc_pkg::PIN_COUNT-1:0] qualified_reg;

    // shift in the new level and test the patterns, pin by pin
    always_comb
    begin
        for (int i = 0; i < pdadc_pkg::PIN_COUNT; i++)
        begin
            hist_next[i] = {hist_reg[i][pdadc_pkg::HIST_BITS-2:0], levels[i]};
            if (hist_next[i] == pdadc_pkg::HIST_ROSE_LOW)
            begin
                qualified_next[i] = 1'b1;
            end
            else if (hist_next[i] == pdadc_pkg::HIST_ROSE_HIGH)
            begin
                qualified_next[i] = 1'b0;
            end
            else
            begin
                qualified_next[i] = qualified_reg[i];
            end
        end
    end

    // advance the histories once per processed tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pdadc_pkg::PIN_COUNT; i++)
            begin
                hist_reg[i] <= pdadc_pkg::HIST_INIT;
            end
            qualified_reg <= '0;
        end
        else if (enable)
        begin
            for (int i = 0; i < pdadc_pkg::PIN_COUNT; i++)
            begin
                hist_reg[i] <= hist_next[i];
            end
            qualified_reg <= qualified_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/pdadc_average.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdadc_average: block averager for the two converter channels
// Accumulates 32 ticks per block and holds half of each block sum.
// ----------------------------------------------------------------------------
module pdadc_average (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             enable,
    input  wire logic [pdadc_pkg::SAMPLE_BITS-1:0] sample_a,
    input  wire logic [pdadc_pkg::SAMPLE_BITS-1:0] sample_b,
    output pdadc_pkg::avg_status_t                status_next,
    output logic                                  block_start
);

    logic [pdadc_pkg::SUM_BITS-1:0]   sum_a_reg, sum_a_next;
    logic [pdadc_pkg::SUM_BITS-1:0]   sum_b_reg, sum_b_next;
    logic [pdadc_pkg::COUNT_BITS-1:0] count_reg, count_next;
    logic [pdadc_pkg::AVG_BITS-1:0]   avg_a_reg, avg_b_reg;
    logic [pdadc_pkg::SUM_BITS-1:0]   total_a, total_b;
    logic                             block_end;

    // add this tick and close the block on its last tick
    always_comb
    begin
        total_a   = sum_a_reg + pdadc_pkg::SUM_BITS'(sample_a);
        total_b   = sum_b_reg + pdadc_pkg::SUM_BITS'(sample_b);
        block_end = (count_reg == pdadc_pkg::LAST_TICK);
        status_next.updated = block_end;
        if (block_end)
        begin
            status_next.average_a = pdadc_pkg::AVG_BITS'(total_a >> 1);
            status_next.average_b = pdadc_pkg::AVG_BITS'(total_b >> 1);
            sum_a_next = '0;
            sum_b_next = '0;
            count_next = '0;
        end
        else
        begin
            status_next.average_a = avg_a_reg;
            status_next.average_b = avg_b_reg;
            sum_a_next = total_a;
            sum_b_next = total_b;
            count_next = count_reg + pdadc_pkg::COUNT_BITS'(1);
        end
    end

    assign block_start = (count_reg == '0);

    // hold the sums and averages between ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            count_reg <= '0;
            avg_a_reg <= '0;
            avg_b_reg <= '0;
        end
        else if (enable)
        begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            count_reg <= count_next;
            avg_a_reg <= status_next.average_a;
            avg_b_reg <= status_next.average_b;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/pin_debounce_and_adc_averager.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pin_debounce_and_adc_averager: pin debounce and converter block averaging
// Top level: input register, debounce and averaging logic, result register.
// ----------------------------------------------------------------------------
// Each sample transfer is one sampling tick and yields exactly one result
// transfer, in order. A tick is registered on entry, processed by the
// per-pin shift-and-compare logic and the two block adders once the result
// register is free, and lands in the result register; a new tick is taken
// every cycle while the result side keeps up. The result register
// frees as it is taken, so the entry register only stalls when both hold an
// item and the result side is stalling. debounced_bits shows a set bit for a
// pin that has qualified low; averages_updated is high on the tick that
// closes each 32-tick block, when average_a and average_b take half the
// block sums. No warm-up sweep is needed after reset.
module pin_debounce_and_adc_averager (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sample_valid,
    output logic                    sample_stall,
    input  wire pdadc_pkg::sample_t sample,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output pdadc_pkg::result_t      result
);

    logic                   entry_valid_reg;
    pdadc_pkg::sample_t     entry_reg;
    logic                   result_valid_reg;
    pdadc_pkg::result_t     result_reg;
    logic                   result_free;
    logic                   process;
    logic [pdadc_pkg::PIN_COUNT-1:0] qualified_next;
    pdadc_pkg::avg_status_t avg_next;
    logic                   block_start;

    // pipeline control
    assign result_free  = !result_valid_reg || !result_stall;
    assign process      = entry_valid_reg && result_free;
    assign sample_stall = entry_valid_reg && !result_free;

    pdadc_debounce u_debounce (
        .clk            (clk),
        .rst_n          (rst_n),
        .enable         (process),
        .levels         (entry_reg.pin_levels),
        .qualified_next (qualified_next)
    );

    pdadc_average u_average (
        .clk         (clk),
        .rst_n       (rst_n),
        .enable      (process),
        .sample_a    (entry_reg.adc_sample_a),
        .sample_b    (entry_reg.adc_sample_b),
        .status_next (avg_next),
        .block_start (block_start)
    );

    // hold the entry register until its tick is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (!sample_stall)
        begin
            entry_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!sample_stall && sample_valid)
        begin
            entry_reg <= sample;
        end
    end

    // advance the result register when it is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (result_free)
        begin
            result_valid_reg <= entry_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            result_reg.debounced_bits   <= qualified_next;
            result_reg.average_a        <= avg_next.average_a;
            result_reg.average_b        <= avg_next.average_b;
            result_reg.averages_updated <= avg_next.updated;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // a stall only occurs with a tick waiting at the entry
    a_stall_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> entry_valid_reg)
        else $error("sample stall without a waiting tick");

    // closing a block restarts the tick count
    a_block_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (process && avg_next.updated) |=> block_start)
        else $error("block count did not restart after block end");

    // a stalled result stays valid and unchanged
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |=> (result_valid_reg && $stable(result_reg)))
        else $error("stalled result changed");

endmodule
`default_nettype wire

FILE: test/pdadc_result_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdadc_result_checker: result prediction and comparison
// Watches both channels of the pin debounce and converter averaging block.
// Every sample transfer runs through a local debounce and block-average
// model and queues the result it should cause. Every result transfer is
// compared field by field with the oldest queued result. The mismatch count
// and the number of results still owed go back to the testbench top.
// ----------------------------------------------------------------------------
module pdadc_result_checker
    import pdadc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    sample_valid,
    input  wire logic    sample_stall,
    input  wire sample_t sample,
    input  wire logic    result_valid,
    input  wire logic    result_stall,
    input  wire result_t result,
    output int           mismatch_count,
    output int           results_pending
);

    // model state: pin shift histories, qualified bits, block sums, held averages
    logic [HIST_BITS-1:0]  pin_shift [PIN_COUNT];
    logic [PIN_COUNT-1:0]  low_qualified;
    logic [SUM_BITS-1:0]   block_sum_a;
    logic [SUM_BITS-1:0]   block_sum_b;
    logic [COUNT_BITS-1:0] tick_in_block;
    logic [AVG_BITS-1:0]   avg_hold_a;
    logic [AVG_BITS-1:0]   avg_hold_b;
    result_t               predicted_results [$];

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t predicted;
        result_t oldest;
        if (!rst_n)
        begin
            for (int i = 0; i < PIN_COUNT; i++)
                pin_shift[i] = HIST_INIT;
            low_qualified = '0;
            block_sum_a   = '0;
            block_sum_b   = '0;
            tick_in_block = '0;
            avg_hold_a    = '0;
            avg_hold_b    = '0;
            predicted_results.delete();
            mismatch_count  = 0;
            results_pending = 0;
        end
        else
        begin
            // predict the result of an accepted sampling tick
            if (sample_valid && !sample_stall)
            begin
                for (int i = 0; i < PIN_COUNT; i++)
                begin
                    pin_shift[i] = {pin_shift[i][HIST_BITS-2:0], sample.pin_levels[i]};
                    if (pin_shift[i] == HIST_ROSE_LOW)
                        low_qualified[i] = 1'b1;
                    else if (pin_shift[i] == HIST_ROSE_HIGH)
                        low_qualified[i] = 1'b0;
                end
                block_sum_a = block_sum_a + SUM_BITS'(sample.adc_sample_a);
                block_sum_b = block_sum_b + SUM_BITS'(sample.adc_sample_b);
                predicted.averages_updated = (tick_in_block == LAST_TICK);
                // close the block: halve the sums and restart
                if (predicted.averages_updated)
                begin
                    avg_hold_a    = AVG_BITS'(block_sum_a >> 1);
                    avg_hold_b    = AVG_BITS'(block_sum_b >> 1);
                    block_sum_a   = '0;
                    block_sum_b   = '0;
                    tick_in_block = '0;
                end
                else
                begin
                    tick_in_block = tick_in_block + 1'b1;
                end
                predicted.debounced_bits = low_qualified;
                predicted.average_a      = avg_hold_a;
                predicted.average_b      = avg_hold_b;
                predicted_results.push_back(predicted);
            end

            // compare an accepted result with the oldest prediction
            if (result_valid && !result_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result: expected none, actual %h", $time, result);
                end
                else
                begin
                    oldest = predicted_results.pop_front();
                    compare_field("debounced_bits", oldest.debounced_bits,
                                  result.debounced_bits);
                    compare_field("average_a", oldest.average_a, result.average_a);
                    compare_field("average_b", oldest.average_b, result.average_b);
                    compare_field("averages_updated", oldest.averages_updated,
                                  result.averages_updated);
                end
            end
            results_pending = predicted_results.size();
        end
    end

endmodule
`default_nettype wire

FILE: test/tb_pin_debounce_and_adc_averager.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_pin_debounce_and_adc_averager: regression for the debounce and averager
// Drives sampling ticks with bouncing and settled pin levels and converter
// samples from zero to full scale, through phases of sender idling and
// receiver stalling, one long receiver hold-off and three full drains. The
// checker alongside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_pin_debounce_and_adc_averager;
    import pdadc_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int TAIL_CYCLES     = 8;
    localparam int FULL_SCALE      = (1 << SAMPLE_BITS) - 1;

    typedef enum {
        SAMPLES_RANDOM,
        SAMPLES_FULL_SCALE,
        SAMPLES_ZERO,
        SAMPLES_NEAR_TOP
    } sample_mode_e;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    sample_valid = 1'b0;
    logic    sample_stall;
    sample_t sample       = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;
    int      mismatch_count;
    int      results_pending;

    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    logic         hold_request   = 1'b0;
    logic         long_hold      = 1'b0;
    int           cycle_count    = 0;
    int           ticks_sent     = 0;
    logic [PIN_COUNT-1:0] pin_level = '1;
    int           run_left [PIN_COUNT];
    sample_mode_e sample_mode    = SAMPLES_RANDOM;

    pin_debounce_and_adc_averager u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    pdadc_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .sample          (sample),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // stall the result side at random, or throughout a hold-off
    always @(posedge clk)
    begin
        result_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
    end

    // hold off the result side for a long stretch once asked
    initial
    begin
        wait (hold_request);
        long_hold <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    // end the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("pin_debounce_and_adc_averager regression: fail");
            $finish;
        end
    end

    // build one tick: pins bounce briefly or settle for long runs, samples by block
    task automatic build_tick(output sample_t s);
        if (ticks_sent % BLOCK_TICKS == 0)
        begin
            case ($urandom_range(9))
                0:       sample_mode = SAMPLES_FULL_SCALE;
                1:       sample_mode = SAMPLES_ZERO;
                2:       sample_mode = SAMPLES_NEAR_TOP;
                default: sample_mode = SAMPLES_RANDOM;
            endcase
        end
        for (int i = 0; i < PIN_COUNT; i++)
        begin
            if (run_left[i] == 0)
            begin
                pin_level[i] = ~pin_level[i];
                run_left[i]  = ($urandom_range(2) == 0) ? $urandom_range(1, 3)
                                                        : $urandom_range(7, 14);
            end
            run_left[i]--;
        end
        s.pin_levels = pin_level;
        // add a glitch now and then, and rarely pure noise
        if ($urandom_range(9) == 0)
            s.pin_levels = s.pin_levels ^ (PIN_COUNT'(1) << $urandom_range(PIN_COUNT - 1));
        if ($urandom_range(19) == 0)
            s.pin_levels = PIN_COUNT'($urandom);
        case (sample_mode)
            SAMPLES_FULL_SCALE:
            begin
                s.adc_sample_a = '1;
                s.adc_sample_b = '1;
            end
            SAMPLES_ZERO:
            begin
                s.adc_sample_a = '0;
                s.adc_sample_b = '0;
            end
            SAMPLES_NEAR_TOP:
            begin
                s.adc_sample_a = SAMPLE_BITS'($urandom_range(FULL_SCALE - 127, FULL_SCALE));
                s.adc_sample_b = SAMPLE_BITS'($urandom_range(FULL_SCALE - 127, FULL_SCALE));
            end
            default:
            begin
                s.adc_sample_a = SAMPLE_BITS'($urandom);
                s.adc_sample_b = SAMPLE_BITS'($urandom);
            end
        endcase
    endtask

    // offer one tick after any idle cycles and hold it until the transfer
    task automatic send_tick(input sample_t s);
        logic stalled;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        do
        begin
            @(negedge clk);
            stalled = sample_stall;
            @(posedge clk);
        end
        while (stalled);
        ticks_sent++;
    endtask

    // drop valid and wait until every predicted result has arrived
    task automatic drain_results();
        sample_valid <= 1'b0;
        do @(negedge clk); while (results_pending != 0);
        @(posedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        sample_t s;
        send_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        repeat (count)
        begin
            build_tick(s);
            send_tick(s);
        end
    endtask

    initial
    begin
        for (int i = 0; i < PIN_COUNT; i++)
            run_left[i] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // seven lows qualify every pin low, one more low holds
        repeat (8) send_tick('{pin_levels: '0, adc_sample_a: '1, adc_sample_b: '1});
        // seven highs release every pin, one more high holds
        repeat (8) send_tick('{pin_levels: '1, adc_sample_a: '0, adc_sample_b: '0});
        // alternating pins never settle
        send_tick('{pin_levels: 9'h155, adc_sample_a: '1, adc_sample_b: '0});
        send_tick('{pin_levels: 9'h0AA, adc_sample_a: '0, adc_sample_b: '1});
        send_tick('{pin_levels: 9'h155, adc_sample_a: 12'hAAA, adc_sample_b: 12'h555});
        send_tick('{pin_levels: 9'h0AA, adc_sample_a: 12'h555, adc_sample_b: 12'hAAA});

        run_phase(0, 0, 300);
        // fill the block against a long hold-off on the result side
        hold_request <= 1'b1;
        run_phase(0, 0, 60);
        drain_results();
        run_phase(83, 0, 300);
        run_phase(0, 83, 300);
        drain_results();
        run_phase(18, 18, 370);

        drain_results();
        recv_stall_pct <= 0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("pin_debounce_and_adc_averager regression: pass");
        else
            $display("pin_debounce_and_adc_averager regression: fail");
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
hdl/pdadc_pkg.sv
hdl/pdadc_debounce.sv
hdl/pdadc_average.sv
hdl/pin_debounce_and_adc_averager.sv
test/pdadc_result_checker.sv
test/tb_pin_debounce_and_adc_averager.sv
